// File: hw/rtl/hhdc_pkg.sv
`default_nettype none

package hhdc_pkg;

	localparam int CNT_W        = 16;
	localparam int HUE_BINS     = 30;
	localparam int SAT_BINS_DEF = 32;
	localparam int HUE_IDX_W    = 5;
	localparam int SAT_IDX_W    = 6;
	localparam int HUE_RANGE    = 180;
	localparam int HUE_RECIP    = 171;
	localparam int HUE_SHIFT    = 10;
	localparam int HUE_STEP     = 6;
	localparam int SCALE_NUM    = 510;
	localparam int SCALE_THR    = 509;
	localparam int THR_W        = CNT_W + 9;

	localparam logic [1:0] COLOUR_NONE   = 2'd0;
	localparam logic [1:0] COLOUR_RED    = 2'd1;
	localparam logic [1:0] COLOUR_YELLOW = 2'd2;
	localparam logic [1:0] COLOUR_BLUE   = 2'd3;

	typedef struct packed {
		logic [7:0] pixel_hue;
		logic [7:0] pixel_sat;
		logic       last_pixel;
	} pix_t;

	typedef struct packed {
		logic [1:0] colour_code;
		logic [4:0] dominant_hue_bin;
		logic [4:0] dominant_sat_bin;
		logic       patch_empty;
	} res_t;

	typedef struct packed {
		logic take;
		logic clr_en;
		logic scan_en;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic addr_last;
	} sts_t;

	function automatic logic [1:0] colour_of(input logic [HUE_IDX_W-1:0] hb);
		logic [7:0] h;
		logic [1:0] c;
		h = 8'(hb) * 8'(HUE_STEP);
		c = COLOUR_NONE;
		if (h < 8'd10 || (h > 8'd160 && h <= 8'd180)) begin
			c = COLOUR_RED;
		end else if (h >= 8'd15 && h < 8'd45) begin
			c = COLOUR_YELLOW;
		end else if (h >= 8'd100 && h < 8'd130) begin
			c = COLOUR_BLUE;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hhdc_ctrl.sv
`default_nettype none

module hhdc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pix_valid,
	input  wire logic          last_pixel,
	output logic               pix_ready,
	output logic               res_valid,
	input  wire logic          res_ready,
	input  wire hhdc_pkg::sts_t sts,
	output hhdc_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_ACCUM,
		ST_DRAIN,
		ST_SCAN,
		ST_FLUSH,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.take        = (state_q == ST_ACCUM) && pix_valid;
		cmd.clr_en      = (state_q == ST_INIT);
		cmd.scan_en     = (state_q == ST_SCAN);
		cmd.load_result = (state_q == ST_RESULT) && (!out_valid_q || res_ready);
	end

	assign pix_ready = (state_q == ST_ACCUM);
	assign res_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.addr_last) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					if (cmd.take && last_pixel) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.addr_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (cmd.load_result) begin
						state_q <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/hhdc_dp.sv
`default_nettype none

module hhdc_dp #(
	parameter int SAT_BINS = hhdc_pkg::SAT_BINS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hhdc_pkg::pix_t pix,
	input  wire hhdc_pkg::cmd_t cmd,
	output hhdc_pkg::sts_t      sts,
	output hhdc_pkg::res_t      res
);

	localparam int NUM_BINS = hhdc_pkg::HUE_BINS * SAT_BINS;
	localparam int ADDR_W   = $clog2(NUM_BINS);
	localparam int CNT_W    = hhdc_pkg::CNT_W;
	localparam int HW       = hhdc_pkg::HUE_IDX_W;
	localparam int SW       = hhdc_pkg::SAT_IDX_W;
	localparam int THR_W    = hhdc_pkg::THR_W;

	logic [CNT_W-1:0] mem_q [NUM_BINS];

	// bin index of the incoming pixel
	logic [15:0]       hue_prod;
	logic [14:0]       sat_prod;
	logic [HW-1:0]     hb;
	logic [SW-1:0]     sb;
	logic [11:0]       idx_wide;
	logic [ADDR_W-1:0] idx_in;
	logic              in_range;

	always_comb begin
		hue_prod = 16'(pix.pixel_hue) * 16'(hhdc_pkg::HUE_RECIP);
		hb       = hue_prod[hhdc_pkg::HUE_SHIFT +: HW];
		sat_prod = 15'(pix.pixel_sat) * 15'(SAT_BINS);
		sb       = sat_prod[8 +: SW];
		idx_wide = 12'(hb) * 12'(SAT_BINS) + 12'(sb);
		idx_in   = idx_wide[ADDR_W-1:0];
		in_range = pix.pixel_hue < 8'(hhdc_pkg::HUE_RANGE);
	end

	// sweep counters
	logic [ADDR_W-1:0] addr_q;
	logic [HW-1:0]     h_q;
	logic [SW-1:0]     s_q;
	logic              advance;

	assign advance       = cmd.clr_en || cmd.scan_en;
	assign sts.addr_last = (addr_q == ADDR_W'(NUM_BINS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			h_q    <= '0;
			s_q    <= '0;
		end else if (advance) begin
			if (sts.addr_last) begin
				addr_q <= '0;
				h_q    <= '0;
				s_q    <= '0;
			end else if (s_q == SW'(SAT_BINS - 1)) begin
				addr_q <= addr_q + 1'b1;
				h_q    <= h_q + 1'b1;
				s_q    <= '0;
			end else begin
				addr_q <= addr_q + 1'b1;
				s_q    <= s_q + 1'b1;
			end
		end
	end

	// pipeline stage one
	logic              acc_vld_s1;
	logic              scan_vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [ADDR_W-1:0] scan_addr_s1;
	logic [HW-1:0]     h_s1;
	logic [SW-1:0]     s_s1;
	logic [CNT_W-1:0]  rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s1  <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			acc_vld_s1  <= cmd.take && in_range;
			scan_vld_s1 <= cmd.scan_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= idx_in;
		scan_addr_s1 <= addr_q;
		h_s1         <= h_q;
		s_s1         <= s_q;
	end

	// bin memory
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CNT_W-1:0]  wr_data;

	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_idx_q;
	logic [CNT_W-1:0]  fwd_cnt_q;
	logic [CNT_W-1:0]  old_cnt;
	logic [CNT_W-1:0]  new_cnt;

	always_comb begin
		rd_en   = cmd.take || cmd.scan_en;
		rd_addr = cmd.scan_en ? addr_q : idx_in;
		old_cnt = (fwd_vld_q && fwd_idx_q == idx_s1) ? fwd_cnt_q : rd_data_s1;
		new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
		wr_en   = acc_vld_s1 || scan_vld_s1 || cmd.clr_en;
		if (acc_vld_s1) begin
			wr_addr = idx_s1;
			wr_data = new_cnt;
		end else if (scan_vld_s1) begin
			wr_addr = scan_addr_s1;
			wr_data = '0;
		end else begin
			wr_addr = addr_q;
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// bypass for back-to-back hits on one bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= acc_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q <= idx_s1;
		fwd_cnt_q <= new_cnt;
	end

	// largest count, threshold and winner search
	logic [CNT_W-1:0] largest_q;
	logic [THR_W-1:0] thr_q;
	logic [THR_W-1:0] scaled;
	logic             hit;
	logic             found_q;
	logic [HW-1:0]    win_h_q;
	logic [SW-1:0]    win_s_q;

	always_comb begin
		scaled = THR_W'(rd_data_s1) * THR_W'(hhdc_pkg::SCALE_NUM);
		hit    = scan_vld_s1 && !found_q && (scaled > thr_q);
	end

	always_ff @(posedge clk) begin
		thr_q <= THR_W'(largest_q) * THR_W'(hhdc_pkg::SCALE_THR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= '0;
			found_q   <= 1'b0;
			win_h_q   <= '0;
			win_s_q   <= '0;
		end else if (cmd.load_result) begin
			largest_q <= '0;
			found_q   <= 1'b0;
			win_h_q   <= '0;
			win_s_q   <= '0;
		end else begin
			if (acc_vld_s1 && new_cnt > largest_q) begin
				largest_q <= new_cnt;
			end
			if (hit) begin
				found_q <= 1'b1;
				win_h_q <= h_s1;
				win_s_q <= s_s1;
			end
		end
	end

	// result word
	hhdc_pkg::res_t res_q;

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_q.patch_empty      <= (largest_q == '0);
			res_q.colour_code      <= (largest_q == '0) ? hhdc_pkg::COLOUR_NONE
				: hhdc_pkg::colour_of(win_h_q);
			res_q.dominant_hue_bin <= win_h_q;
			res_q.dominant_sat_bin <= win_s_q[4:0];
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/hue_histogram_dominant_colour_core.sv
`default_nettype none

// Hue/saturation histogram dominant-colour core. Pixels of a patch stream in
// at one per cycle and are counted into a 30 x SAT_BINS bin memory (16-bit
// saturating counts, single write port with a bypass for repeated bins).
// After the pixel flagged last, the core stalls input while it retires the
// last count, then makes one memory read per bin while the winner is searched
// and each bin is zeroed for the next patch, then flushes the last read and
// loads the result word once the output register is free or being taken. The
// result sits in an output register, so the next patch may start before it
// is taken. After reset the bin memory is swept to zero, one bin at a time,
// before the first pixel is accepted.
module hue_histogram_dominant_colour_core #(
	parameter int SAT_BINS = hhdc_pkg::SAT_BINS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pix_valid,
	output logic                pix_ready,
	input  wire hhdc_pkg::pix_t pix,
	output logic                res_valid,
	input  wire logic           res_ready,
	output hhdc_pkg::res_t      res
);

	hhdc_pkg::cmd_t cmd;
	hhdc_pkg::sts_t sts;

	hhdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.last_pixel (pix.last_pixel),
		.pix_ready  (pix_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	hhdc_dp #(
		.SAT_BINS (SAT_BINS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	a_no_take_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take && (cmd.scan_en || cmd.clr_en)))
		else $error("pixel taken during a memory sweep");

	a_load_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> res_valid)
		else $error("loaded result word not presented");

	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && pix.last_pixel) |=> !pix_ready)
		else $error("input not stalled after last pixel");

endmodule

`default_nettype wire
